/* hdl/cbm_pkg.sv */
// Package: shared types, codes and helpers of the codebook background model.
package cbm_pkg;

    typedef logic [2:0][7:0] t_chan3;

    typedef enum logic [1:0] {
        FN_LEARN  = 2'd0,
        FN_CLEAR  = 2'd1,
        FN_DETECT = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EXEC
    } t_state;

    localparam logic [2:0] CFG_BOUND_C0     = 3'd0;
    localparam logic [2:0] CFG_BOUND_C1     = 3'd1;
    localparam logic [2:0] CFG_BOUND_C2     = 3'd2;
    localparam logic [2:0] CFG_MARGIN_BELOW = 3'd3;
    localparam logic [2:0] CFG_MARGIN_ABOVE = 3'd4;

    localparam logic [7:0] BOUND_RST  = 8'd10;
    localparam logic [7:0] MARGIN_RST = 8'd20;
    localparam logic [7:0] CHAN_MAX   = 8'd255;

    typedef struct packed {
        t_func       func;
        logic [11:0] pixel_index;
        logic [7:0]  sample_c0;
        logic [7:0]  sample_c1;
        logic [7:0]  sample_c2;
    } t_in;

    typedef struct packed {
        logic       foreground;
        logic [3:0] entry_slot;
        logic       table_full;
        logic [3:0] removed_count;
    } t_out;

    typedef struct packed {
        logic learn_hit;
        logic det_hit;
        logic keep;
    } t_lane_flags;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? CHAN_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : 8'd0;
    endfunction

endpackage

/* hdl/cbm_ram.sv */
// Generic single write port RAM with registered read.
module cbm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [(D > 1 ? $clog2(D) : 1)-1:0]  i_raddr,
    output logic [W-1:0]                        o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/cbm_lane.sv */
// One codebook entry lane: match tests and candidate updates for one entry.
module cbm_lane
    import cbm_pkg::*;
#(
    parameter int TB = 16
) (
    input  logic [96+2*TB-1:0] i_entry,
    input  logic               i_valid,
    input  t_chan3             i_smp,
    input  t_chan3             i_lo_t,
    input  t_chan3             i_hi_t,
    input  logic [TB-1:0]      i_tick,
    input  logic [TB-1:0]      i_thr,
    input  logic [7:0]         i_mb,
    input  logic [7:0]         i_ma,
    output t_lane_flags        o_flags,
    output logic [96+2*TB-1:0] o_match,
    output logic [96+2*TB-1:0] o_other
);
    typedef struct packed {
        t_chan3        lo;
        t_chan3        hi;
        t_chan3        mn;
        t_chan3        mx;
        logic [TB-1:0] last;
        logic [TB-1:0] stale;
    } t_entry;

    t_entry        e, em, eo;
    logic          lh, dh;
    logic [TB-1:0] run;

    always_comb begin
        e  = t_entry'(i_entry);
        em = e;
        eo = e;
        lh = 1'b1;
        dh = 1'b1;
        for (int n = 0; n < 3; n++) begin
            if (!(e.lo[n] <= i_smp[n] && e.hi[n] >= i_smp[n])) begin
                lh = 1'b0;
            end
            if (!(({1'b0, i_smp[n]} + {1'b0, i_mb}) >= {1'b0, e.mn[n]} &&
                  {1'b0, i_smp[n]} <= ({1'b0, e.mx[n]} + {1'b0, i_ma}))) begin
                dh = 1'b0;
            end
            if (e.mx[n] < i_smp[n]) begin
                em.mx[n] = i_smp[n];
            end else if (e.mn[n] > i_smp[n]) begin
                em.mn[n] = i_smp[n];
            end
            if (e.hi[n] < i_hi_t[n]) begin
                em.hi[n] = e.hi[n] + 8'd1;
            end
            if (e.lo[n] > i_lo_t[n]) begin
                em.lo[n] = e.lo[n] - 8'd1;
            end
        end
        em.last = i_tick;
        run = (i_tick >= e.last) ? i_tick - e.last : '0;
        if (e.stale < run) begin
            eo.stale = run;
        end
        o_flags.learn_hit = i_valid & lh;
        o_flags.det_hit   = i_valid & dh;
        o_flags.keep      = i_valid & (e.stale <= i_thr);
    end

    assign o_match = em;
    assign o_other = eo;
endmodule

/* hdl/cbm_merge.sv */
// Merge stage: picks the first hit, appends, compacts and forms the result.
module cbm_merge
    import cbm_pkg::*;
#(
    parameter int NE = 8,
    parameter int TB = 16,
    parameter int CW = 4
) (
    input  t_func                         i_func,
    input  logic [CW-1:0]                 i_cnt,
    input  logic [NE-1:0][96+2*TB-1:0]    i_entry,
    input  logic [NE-1:0][96+2*TB-1:0]    i_match,
    input  logic [NE-1:0][96+2*TB-1:0]    i_other,
    input  t_lane_flags [NE-1:0]          i_flags,
    input  logic [TB-1:0]                 i_tick,
    input  t_chan3                        i_smp,
    input  t_chan3                        i_lo_t,
    input  t_chan3                        i_hi_t,
    output logic [NE-1:0][96+2*TB-1:0]    o_book,
    output logic [CW-1:0]                 o_cnt,
    output t_out                          o_out
);
    localparam int IW = (NE > 1) ? $clog2(NE) : 1;

    typedef struct packed {
        t_chan3        lo;
        t_chan3        hi;
        t_chan3        mn;
        t_chan3        mx;
        logic [TB-1:0] last;
        logic [TB-1:0] stale;
    } t_entry;

    logic          found, fgh;
    logic [CW-1:0] m, k;
    t_entry        enew, ek;

    always_comb begin
        found = 1'b0;
        fgh   = 1'b0;
        m     = '0;
        k     = '0;
        o_book = i_entry;
        o_cnt  = i_cnt;
        o_out  = '0;
        o_out.entry_slot = 4'(NE);
        enew.lo    = i_lo_t;
        enew.hi    = i_hi_t;
        enew.mn    = i_smp;
        enew.mx    = i_smp;
        enew.last  = i_tick;
        enew.stale = '0;
        ek = '0;
        for (int i = NE - 1; i >= 0; i--) begin
            if (i_flags[i].learn_hit) begin
                found = 1'b1;
                m     = CW'(i);
            end
            if (i_flags[i].det_hit) begin
                fgh = 1'b1;
            end
        end
        case (i_func)
            FN_LEARN: begin
                for (int i = 0; i < NE; i++) begin
                    if (found && m == CW'(i)) begin
                        o_book[i] = i_match[i];
                    end else if (CW'(i) < i_cnt) begin
                        o_book[i] = i_other[i];
                    end else if (!found && CW'(i) == i_cnt) begin
                        o_book[i] = enew;
                    end
                end
                if (found) begin
                    o_out.entry_slot = 4'(m);
                end else if (i_cnt < CW'(NE)) begin
                    o_out.entry_slot = 4'(i_cnt);
                    o_cnt = i_cnt + CW'(1);
                end else begin
                    o_out.table_full = 1'b1;
                end
            end
            FN_CLEAR: begin
                // k never passes the lane being kept, so it stays below NE here
                for (int i = 0; i < NE; i++) begin
                    if (i_flags[i].keep) begin
                        ek      = t_entry'(i_entry[i]);
                        ek.last = '0;
                        o_book[k[IW-1:0]] = ek;
                        k = k + CW'(1);
                    end
                end
                o_cnt = k;
                o_out.removed_count = 4'(i_cnt - k);
            end
            FN_DETECT: begin
                o_out.foreground = ~fgh;
            end
            default: begin
                o_cnt = i_cnt;
            end
        endcase
    end
endmodule

/* hdl/codebook_background_model.sv */
// Codebook background model: one transfer per item, one result transfer per item.
// The pixel's whole codebook and count/tick word are read from RAM in the accept cycle;
// in the execute state all entry lanes compare and update it in parallel, the result
// register is loaded and, for an in-range pixel, the count/tick word (and for learn
// and clear the codebook) is written back. A new item is taken once the block is back
// in idle; a result held by stall on the output side delays the write-back. After
// reset a clearing pass zeroes the per-pixel count/tick RAM and accepts no item.
module codebook_background_model
    import cbm_pkg::*;
#(
    parameter int PIXELS    = 4096,
    parameter int ENTRIES   = 8,
    parameter int TIME_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = 96 + 2 * TIME_BITS;
    localparam int MW = CW + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wipe, n_wipe;
    t_in             r_item;
    logic            r_inrange;
    t_out            r_out;
    logic            r_out_valid;
    t_chan3          r_bound;
    logic [7:0]      r_mb, r_ma;

    logic            accept, done, in_range;
    logic [31:0]     px32;
    logic [AW-1:0]   in_addr, waddr;
    logic [MW-1:0]   meta_rd, meta_wd;
    logic            meta_we, book_we;
    logic [ENTRIES-1:0][EW-1:0] book_rd, book_wd, lane_m, lane_o;
    t_lane_flags [ENTRIES-1:0]  flags;
    logic [CW-1:0]   cnt_raw, cnt, cnt_n;
    logic [TIME_BITS-1:0] tick, tick_t, tick_n;
    t_chan3          smp, lo_t, hi_t;
    t_out            mres, res;

    assign px32     = 32'(i_in_data.pixel_index);
    assign in_addr  = px32[AW-1:0];
    assign in_range = px32 < 32'(PIXELS);
    assign accept   = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign done     = (r_state == ST_EXEC) & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= {BOUND_RST, BOUND_RST, BOUND_RST};
            r_mb    <= MARGIN_RST;
            r_ma    <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOUND_C0:     r_bound[0] <= i_cfg_data;
                CFG_BOUND_C1:     r_bound[1] <= i_cfg_data;
                CFG_BOUND_C2:     r_bound[2] <= i_cfg_data;
                CFG_MARGIN_BELOW: r_mb       <= i_cfg_data;
                CFG_MARGIN_ABOVE: r_ma       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_wipe      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wipe  <= n_wipe;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (~i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_in_data;
            r_inrange <= in_range;
        end
        if (done) begin
            r_out <= res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wipe  = r_wipe;
        case (r_state)
            ST_WIPE: begin
                n_wipe = r_wipe + AW'(1);
                if (32'(r_wipe) == 32'(PIXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_WIPE;
        endcase
    end

    // count/tick word
    assign {cnt_raw, tick} = meta_rd;
    assign cnt    = (cnt_raw > CW'(ENTRIES)) ? CW'(ENTRIES) : cnt_raw;
    assign tick_t = (tick < TMAX) ? tick + TIME_BITS'(1) : tick;
    assign smp    = {r_item.sample_c2, r_item.sample_c1, r_item.sample_c0};

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            hi_t[n] = sat_add(smp[n], r_bound[n]);
            lo_t[n] = sat_sub(smp[n], r_bound[n]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_lane
            cbm_lane #(.TB(TIME_BITS)) u_lane (
                .i_entry (book_rd[g]),
                .i_valid (CW'(g) < cnt),
                .i_smp   (smp),
                .i_lo_t  (lo_t),
                .i_hi_t  (hi_t),
                .i_tick  (tick_t),
                .i_thr   (tick >> 1),
                .i_mb    (r_mb),
                .i_ma    (r_ma),
                .o_flags (flags[g]),
                .o_match (lane_m[g]),
                .o_other (lane_o[g])
            );
        end
    endgenerate

    cbm_merge #(.NE(ENTRIES), .TB(TIME_BITS), .CW(CW)) u_merge (
        .i_func  (r_item.func),
        .i_cnt   (cnt),
        .i_entry (book_rd),
        .i_match (lane_m),
        .i_other (lane_o),
        .i_flags (flags),
        .i_tick  (tick_t),
        .i_smp   (smp),
        .i_lo_t  (lo_t),
        .i_hi_t  (hi_t),
        .o_book  (book_wd),
        .o_cnt   (cnt_n),
        .o_out   (mres)
    );

    always_comb begin
        res     = '0;
        res.entry_slot = 4'(ENTRIES);
        meta_we = 1'b0;
        book_we = 1'b0;
        tick_n  = tick_t;
        if (r_state == ST_WIPE) begin
            meta_we = 1'b1;
        end else if (done && r_inrange) begin
            case (r_item.func)
                FN_LEARN: begin
                    res = mres; meta_we = 1'b1; book_we = 1'b1;
                end
                FN_CLEAR: begin
                    res = mres; meta_we = 1'b1; book_we = 1'b1; tick_n = '0;
                end
                FN_DETECT: begin
                    res = mres; meta_we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign waddr   = (r_state == ST_WIPE) ? r_wipe : r_item.pixel_index[AW-1:0] & '1;
    assign meta_wd = (r_state == ST_WIPE) ? '0 : {cnt_n, tick_n};

    cbm_ram #(.W(MW), .D(PIXELS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (waddr),
        .i_wdata (meta_wd),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (meta_rd)
    );

    cbm_ram #(.W(ENTRIES * EW), .D(PIXELS)) u_book (
        .i_clk   (i_clk),
        .i_we    (book_we),
        .i_waddr (waddr),
        .i_wdata (book_wd),
        .i_re    (accept),
        .i_raddr (in_addr),
        .o_rdata (book_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted item did not start execution");
    a_wipe_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIPE) |-> o_in_stall)
        else $error("input taken during clearing pass");
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full) |->
            (o_out_data.entry_slot == 4'(ENTRIES) && o_out_data.removed_count == 4'd0
             && !o_out_data.foreground))
        else $error("full flag with inconsistent result");
endmodule
